>>> hw/rtl/modbus_rtu_request_checker_defines.svh
// Assertion macros for the Modbus RTU request checker.
`ifndef MODBUS_RTU_REQUEST_CHECKER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define MRRC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("mrrc assertion failed");

// cond at one edge implies res at the next edge
`define MRRC_ASSERT_NEXT(label, clk, rst_n, cond, res) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
		else $error("mrrc assertion failed");

`else

`define MRRC_ASSERT(label, clk, rst_n, prop)
`define MRRC_ASSERT_NEXT(label, clk, rst_n, cond, res)

`endif

`endif

>>> hw/rtl/mrrc_pkg.sv
// Shared types, constants and CRC table for the Modbus RTU request checker.
package mrrc_pkg;

	localparam int unsigned MAX_FRAME = 256;
	localparam int unsigned HDR_LEN   = 7;
	localparam int unsigned LEN_W     = 9;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [7:0] FC_READ_LO  = 8'h01;
	localparam logic [7:0] FC_READ_HI  = 8'h04;
	localparam logic [7:0] FC_WR_COIL  = 8'h05;
	localparam logic [7:0] FC_WR_REG   = 8'h06;
	localparam logic [7:0] FC_WR_COILS = 8'h0F;
	localparam logic [7:0] FC_WR_REGS  = 8'h10;

	localparam logic [LEN_W-1:0] FIXED_LEN = LEN_W'(8);
	localparam logic [LEN_W:0]   RD_OVHD   = (LEN_W+1)'(5);
	localparam logic [LEN_W:0]   WR_OVHD   = (LEN_W+1)'(9);

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_ADDR = 3'd1,
		ST_FUNC = 3'd2,
		ST_WLEN = 3'd3,
		ST_RLEN = 3'd4,
		ST_CRC  = 3'd5
	} status_t;

	// frame state as seen after the current beat is folded in
	typedef struct packed {
		logic [HDR_LEN-1:0][7:0] hdr;
		logic [LEN_W-1:0]        len;
		logic [15:0]             crc;
		logic                    overlong;
	} frame_sum_t;

	// reflected 0xA001 CRC-16, one nibble
	function automatic logic [15:0] crc_nib(input logic [3:0] idx);
		logic [15:0] v;
		unique case (idx)
			4'h0: v = 16'h0000;
			4'h1: v = 16'hCC01;
			4'h2: v = 16'hD801;
			4'h3: v = 16'h1400;
			4'h4: v = 16'hF001;
			4'h5: v = 16'h3C00;
			4'h6: v = 16'h2800;
			4'h7: v = 16'hE401;
			4'h8: v = 16'hA001;
			4'h9: v = 16'h6C00;
			4'hA: v = 16'h7800;
			4'hB: v = 16'hB401;
			4'hC: v = 16'h5000;
			4'hD: v = 16'h9C01;
			4'hE: v = 16'h8801;
			4'hF: v = 16'h4400;
			default: v = 16'h0000;
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/mrrc_crc.sv
// CRC-16 byte update, two nibble table lookups.
module mrrc_crc (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	logic [15:0] mid;

	always_comb begin
		mid     = {4'h0, crc_in[15:4]} ^ mrrc_pkg::crc_nib(crc_in[3:0] ^ data[3:0]);
		crc_out = {4'h0, mid[15:4]} ^ mrrc_pkg::crc_nib(mid[3:0] ^ data[7:4]);
	end

endmodule

>>> hw/rtl/mrrc_frame.sv
// Per-frame state: running CRC, byte count, header bytes, overlong flag.
module mrrc_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data,
	input  logic                  last,
	output mrrc_pkg::frame_sum_t  sum
);

	logic [15:0]                              crc_q;
	logic [mrrc_pkg::LEN_W-1:0]               count_q;
	logic [mrrc_pkg::HDR_LEN-1:0][7:0]        hdr_q;
	logic                                     overlong_q;
	logic [15:0]                              crc_n;
	logic                                     full;

	mrrc_crc u_crc (
		.crc_in  (crc_q),
		.data    (data),
		.crc_out (crc_n)
	);

	always_comb begin
		full = (count_q == mrrc_pkg::LEN_W'(mrrc_pkg::MAX_FRAME));
		sum.crc = crc_n;
		sum.overlong = overlong_q | full;
		sum.len = full ? count_q : count_q + mrrc_pkg::LEN_W'(1);
		for (int i = 0; i < mrrc_pkg::HDR_LEN; i++) begin
			sum.hdr[i] = (count_q == mrrc_pkg::LEN_W'(i)) ? data : hdr_q[i];
		end
	end

	// final beat folds in, then everything returns to its idle values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= mrrc_pkg::CRC_INIT;
			count_q    <= '0;
			hdr_q      <= '0;
			overlong_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				crc_q      <= mrrc_pkg::CRC_INIT;
				count_q    <= '0;
				hdr_q      <= '0;
				overlong_q <= 1'b0;
			end else begin
				crc_q      <= sum.crc;
				count_q    <= sum.len;
				hdr_q      <= sum.hdr;
				overlong_q <= sum.overlong;
			end
		end
	end

endmodule

>>> hw/rtl/mrrc_check.sv
// Request checks: address, function class, length, CRC residue.
module mrrc_check (
	input  mrrc_pkg::frame_sum_t  sum,
	input  logic [7:0]            slave_address,
	output mrrc_pkg::status_t     status,
	output logic                  is_write
);

	logic [7:0]                 fc;
	logic                       rd_class;
	logic                       wr_class;
	logic                       len_ok;
	logic [mrrc_pkg::LEN_W:0]   len_x;

	always_comb begin
		fc       = sum.hdr[1];
		len_x    = {1'b0, sum.len};
		rd_class = (fc >= mrrc_pkg::FC_READ_LO) && (fc <= mrrc_pkg::FC_READ_HI);
		wr_class = (fc == mrrc_pkg::FC_WR_COIL) || (fc == mrrc_pkg::FC_WR_REG) ||
		           (fc == mrrc_pkg::FC_WR_COILS) || (fc == mrrc_pkg::FC_WR_REGS);

		// byte 6 is the data byte count of a multi-write, byte 2 that of a read reply
		if (wr_class) begin
			len_ok = (sum.len == mrrc_pkg::FIXED_LEN) ||
			         ((len_x == mrrc_pkg::WR_OVHD + {2'b00, sum.hdr[6]}) &&
			          ({1'b0, sum.hdr[6]} == {sum.hdr[5], 1'b0}));
		end else begin
			len_ok = (sum.len == mrrc_pkg::FIXED_LEN) ||
			         (len_x == mrrc_pkg::RD_OVHD + {2'b00, sum.hdr[2]});
		end

		is_write = 1'b0;
		priority if (sum.hdr[0] != slave_address) begin
			status = mrrc_pkg::ST_ADDR;
		end else if (!rd_class && !wr_class) begin
			status = mrrc_pkg::ST_FUNC;
		end else begin
			is_write = wr_class;
			if (sum.overlong || !len_ok) begin
				status = wr_class ? mrrc_pkg::ST_WLEN : mrrc_pkg::ST_RLEN;
			end else if (sum.crc != 16'h0000) begin
				status = mrrc_pkg::ST_CRC;
			end else begin
				status = mrrc_pkg::ST_OK;
			end
		end
	end

endmodule

>>> hw/rtl/modbus_rtu_request_checker.sv
// A final byte passes through the input register, then the result register, to res_valid.
// Throughput: one byte per cycle; the input register and result register are decoupled,
// so only a final byte waiting behind a stalled, full result register holds req_stall.
// Frame state (CRC, count, header) advances one byte per cycle and clears on the final byte.
// Reset (arst_n low) empties both registers, clears frame state, sets slave_address to 1.
`include "modbus_rtu_request_checker_defines.svh"

module modbus_rtu_request_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [7:0]  rx_byte,
	input  logic        last_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  status,
	output logic        is_write,
	output logic [8:0]  frame_length
);

	logic [7:0]            slave_address_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic                  adv_s1;
	logic                  load_s1;
	logic                  res_valid_q;
	mrrc_pkg::status_t     status_q;
	logic                  is_write_q;
	logic [8:0]            len_q;
	mrrc_pkg::frame_sum_t  sum;
	mrrc_pkg::status_t     chk_status;
	logic                  chk_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'h01;
		end else if (cfg_wr_en) begin
			slave_address_q <= cfg_wr_data;
		end
	end

	// only a final beat needs room in the result register
	assign adv_s1    = valid_s1 & ~(last_s1 & res_valid_q & res_stall);
	assign load_s1   = ~valid_s1 | adv_s1;
	assign req_stall = ~load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && req_valid) begin
			byte_s1 <= rx_byte;
			last_s1 <= last_byte;
		end
	end

	mrrc_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.data   (byte_s1),
		.last   (last_s1),
		.sum    (sum)
	);

	mrrc_check u_check (
		.sum           (sum),
		.slave_address (slave_address_q),
		.status        (chk_status),
		.is_write      (chk_write)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			status_q   <= chk_status;
			is_write_q <= chk_write;
			len_q      <= sum.len;
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign is_write     = is_write_q;
	assign frame_length = len_q;

	`MRRC_ASSERT(a_stall_cause, clk, arst_n, req_stall |-> (valid_s1 && last_s1 && res_valid_q && res_stall))
	`MRRC_ASSERT(a_len_bound, clk, arst_n, res_valid_q |-> (len_q <= 9'(mrrc_pkg::MAX_FRAME)))
	`MRRC_ASSERT(a_err_read, clk, arst_n, (res_valid_q && (status_q == mrrc_pkg::ST_ADDR || status_q == mrrc_pkg::ST_FUNC)) |-> !is_write_q)
	`MRRC_ASSERT_NEXT(a_final_out, clk, arst_n, adv_s1 && last_s1, res_valid_q)

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the Modbus RTU request checker: directed table, then random frames.
module tb_top;
	import mrrc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_BEATS    = 490;

	typedef struct packed {
		status_t    st;
		logic       wr;
		logic [8:0] len;
	} verdict_t;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       pinned;
		verdict_t   v;
	} stim_row_t;

	typedef enum int {
		FR_READ8,
		FR_READ_VAR,
		FR_WRITE8,
		FR_WRITE_VAR,
		FR_READ_MAX,
		FR_WRITE_OVER
	} frame_shape_t;

	localparam verdict_t NO_VERDICT = '{ST_OK, 1'b0, 9'd0};

	localparam logic [7:0] WR_CODES [4] = '{FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS};

	// pinned rows carry the status that can be read straight off the frame
	localparam stim_row_t DIR_TAB [25] = '{
		'{8'h00, 1'b1, 1'b1, '{ST_ADDR, 1'b0, 9'd1}},
		'{8'hFF, 1'b1, 1'b1, '{ST_ADDR, 1'b0, 9'd1}},
		'{8'h01, 1'b1, 1'b1, '{ST_FUNC, 1'b0, 9'd1}},
		'{8'h01, 1'b0, 1'b0, NO_VERDICT},
		'{8'hFF, 1'b1, 1'b1, '{ST_FUNC, 1'b0, 9'd2}},
		'{8'h01, 1'b0, 1'b0, NO_VERDICT},
		'{8'h03, 1'b1, 1'b1, '{ST_RLEN, 1'b0, 9'd2}},
		'{8'h01, 1'b0, 1'b0, NO_VERDICT},
		'{8'h10, 1'b1, 1'b1, '{ST_WLEN, 1'b1, 9'd2}},
		'{8'h01, 1'b0, 1'b0, NO_VERDICT},
		'{8'h03, 1'b0, 1'b0, NO_VERDICT},
		'{8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{8'h0A, 1'b0, 1'b0, NO_VERDICT},
		'{8'hC5, 1'b0, 1'b0, NO_VERDICT},
		'{8'hCD, 1'b1, 1'b0, NO_VERDICT},
		'{8'h01, 1'b0, 1'b0, NO_VERDICT},
		'{8'h03, 1'b0, 1'b0, NO_VERDICT},
		'{8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{8'h0A, 1'b0, 1'b0, NO_VERDICT},
		'{8'hC5, 1'b0, 1'b0, NO_VERDICT},
		'{8'hCC, 1'b1, 1'b1, '{ST_CRC, 1'b0, 9'd8}}
	};

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       req_valid   = 1'b0;
	logic [7:0] rx_byte     = 8'h00;
	logic       last_byte   = 1'b0;
	logic       res_stall   = 1'b0;
	logic       req_stall;
	logic       res_valid;
	logic [2:0] status;
	logic       is_write;
	logic [8:0] frame_length;

	// request predictor state
	logic [15:0] calc_crc      = 16'hFFFF;
	logic [8:0]  calc_count    = '0;
	logic [7:0]  calc_hdr [HDR_LEN] = '{default: 8'h00};
	logic        calc_overlong = 1'b0;
	logic [7:0]  station_addr  = 8'h01;

	verdict_t   verdict_q [$];
	logic [7:0] frame_q [$];
	bit         steady = 1'b0;
	int         beats_sent = 0;
	int         mismatches = 0;
	int         stuck_cycles = 0;

	modbus_rtu_request_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.rx_byte      (rx_byte),
		.last_byte    (last_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.status       (status),
		.is_write     (is_write),
		.frame_length (frame_length)
	);

	always #5 clk = ~clk;

	// bitwise reflected CRC-16, poly 0xA001
	function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] b);
		c = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction

	task automatic fold_beat(input logic [7:0] b, input logic l, output logic done,
			output verdict_t v);
		logic [7:0] fc;
		logic       len_ok;
		done = 1'b0;
		v = NO_VERDICT;
		if (calc_count < HDR_LEN)
			calc_hdr[calc_count] = b;
		calc_crc = crc16_fold(calc_crc, b);
		if (calc_count >= MAX_FRAME)
			calc_overlong = 1'b1;
		else
			calc_count++;
		if (l) begin
			fc = calc_hdr[1];
			v.len = calc_count;
			if (calc_hdr[0] != station_addr)
				v.st = ST_ADDR;
			else if (fc >= FC_READ_LO && fc <= FC_READ_HI)
				v.wr = 1'b0;
			else if (fc == FC_WR_COIL || fc == FC_WR_REG || fc == FC_WR_COILS ||
					fc == FC_WR_REGS)
				v.wr = 1'b1;
			else
				v.st = ST_FUNC;
			if (v.st == ST_OK) begin
				if (v.wr)
					len_ok = calc_count == FIXED_LEN ||
						(int'(calc_count) == int'(WR_OVHD) + int'(calc_hdr[6]) &&
						 int'(calc_hdr[6]) == 2 * int'(calc_hdr[5]));
				else
					len_ok = calc_count == FIXED_LEN ||
						int'(calc_count) == int'(RD_OVHD) + int'(calc_hdr[2]);
				if (calc_overlong || !len_ok)
					v.st = v.wr ? ST_WLEN : ST_RLEN;
				else if (calc_crc != 16'h0000)
					v.st = ST_CRC;
			end
			done = 1'b1;
			calc_crc = 16'hFFFF;
			calc_count = '0;
			foreach (calc_hdr[i])
				calc_hdr[i] = 8'h00;
			calc_overlong = 1'b0;
		end
	endtask

	task automatic send_beat(input logic [7:0] b, input logic l, input logic pinned,
			input verdict_t pv);
		logic     done;
		verdict_t v;
		while (!steady && $urandom_range(99) < 23) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		rx_byte   <= b;
		last_byte <= l;
		do begin
			@(posedge clk);
		end while (req_stall);
		beats_sent++;
		fold_beat(b, l, done, v);
		if (done)
			verdict_q.push_back(pinned ? pv : v);
	endtask

	// drain everything in flight, then change the station address
	task automatic set_station(input logic [7:0] a);
		req_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= a;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		station_addr = a;
	endtask

	// request with trailing CRC, low byte first; well-formed but for FR_WRITE_OVER, which runs past MAX_FRAME
	task automatic build_frame(input frame_shape_t shape);
		logic [15:0] c;
		logic [7:0]  n;
		frame_q.delete();
		frame_q.push_back(station_addr);
		if (shape == FR_READ8 || shape == FR_READ_VAR || shape == FR_READ_MAX)
			frame_q.push_back(8'($urandom_range(FC_READ_LO, FC_READ_HI)));
		else
			frame_q.push_back(WR_CODES[$urandom_range(3)]);
		case (shape)
			FR_READ_VAR, FR_READ_MAX: begin
				n = (shape == FR_READ_MAX) ? 8'd251 : 8'($urandom_range(20));
				frame_q.push_back(n);
				repeat (n) frame_q.push_back(8'($urandom));
			end
			FR_WRITE_VAR, FR_WRITE_OVER: begin
				// byte count is twice the register count
				n = (shape == FR_WRITE_OVER) ? 8'd127 : 8'($urandom_range(10));
				repeat (3) frame_q.push_back(8'($urandom));
				frame_q.push_back(n);
				frame_q.push_back(n << 1);
				repeat (2 * n) frame_q.push_back(8'($urandom));
			end
			default: begin
				repeat (4) frame_q.push_back(8'($urandom));
			end
		endcase
		c = 16'hFFFF;
		foreach (frame_q[i])
			c = crc16_fold(c, frame_q[i]);
		frame_q.push_back(c[7:0]);
		frame_q.push_back(c[15:8]);
	endtask

	always @(posedge clk)
		res_stall <= !steady && ($urandom_range(99) < 23);

	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: status %0d is_write %0d frame_length %0d",
						status, is_write, frame_length);
			end else begin
				want = verdict_q.pop_front();
				if (status !== want.st || is_write !== want.wr ||
						frame_length !== want.len) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected status %0d is_write %0d len %0d, ",
							"got status %0d is_write %0d len %0d"},
							want.st, want.wr, want.len, status, is_write, frame_length);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
			stuck_cycles <= 0;
		else if (stuck_cycles == WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		logic [7:0] phase_addr [4];
		int         start;
		int         k;
		int         cut;
		int         idx;
		bit         first;
		phase_addr = '{8'h00, 8'hFF, 8'($urandom_range(2, 254)), 8'h01};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TAB[i])
			send_beat(DIR_TAB[i].b, DIR_TAB[i].l, DIR_TAB[i].pinned, DIR_TAB[i].v);

		for (int ph = 0; ph < 4; ph++) begin
			set_station(phase_addr[ph]);
			steady = (ph == 1);
			start = beats_sent;
			first = 1'b1;
			while (beats_sent - start < PHASE_BEATS) begin
				if (first && ph == 0)
					build_frame(FR_READ_MAX);
				else if (first && ph == 2)
					build_frame(FR_WRITE_OVER);
				else begin
					build_frame(frame_shape_t'($urandom_range(3)));
					k = $urandom_range(99);
					if (k < 8) begin
						idx = $urandom_range(frame_q.size() - 1);
						frame_q[idx] = frame_q[idx] ^ 8'(1 << $urandom_range(7));
					end else if (k < 14)
						frame_q[0] = 8'($urandom);
					else if (k < 20)
						frame_q[1] = 8'($urandom);
					else if (k < 26) begin
						cut = $urandom_range(1, frame_q.size() - 1);
						while (frame_q.size() > cut)
							void'(frame_q.pop_back());
					end else if (k < 30)
						repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
					else if (k < 36) begin
						frame_q.delete();
						repeat ($urandom_range(1, 16)) frame_q.push_back(8'($urandom));
					end else if (k == 99) begin
						// runs past MAX_FRAME with a valid header
						cut = 257 + $urandom_range(13);
						while (frame_q.size() < cut)
							frame_q.push_back(8'($urandom));
					end
				end
				first = 1'b0;
				foreach (frame_q[i])
					send_beat(frame_q[i], i == frame_q.size() - 1, 1'b0, NO_VERDICT);
			end
		end

		steady = 1'b0;
		req_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
